@@ hdl/fet_pkg.sv @@
// Shared types and constants for the FAT entry table engine.
// Used by fet_front, fet_back and fat_entry_table_engine_top; no dependencies.
package fet_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_STORE_CLUSTERS    = 64;
  localparam int DEF_LIST_DEPTH        = 32;
  localparam int DEF_MAX_CLUSTER_WORDS = 256;

  // Field widths of the queued item, sized for the largest parameter values
  localparam int LIDX_W    = 6;   // list index, LIST_DEPTH up to 64
  localparam int OFF_W     = 8;   // word offset, MAX_CLUSTER_WORDS up to 256
  localparam int CLUSTER_W = 21;
  localparam int LADDR_W   = 14;
  localparam int LOG2_W    = 4;
  localparam int QUEUE_DEPTH = 2;

  // Command codes on cmd_i
  localparam logic [2:0] CMD_GET_PLAIN  = 3'd0;
  localparam logic [2:0] CMD_GET_MASK   = 3'd1;
  localparam logic [2:0] CMD_SET        = 3'd2;
  localparam logic [2:0] CMD_SET_RESET  = 3'd3;
  localparam logic [2:0] CMD_LOAD_WORD  = 3'd4;
  localparam logic [2:0] CMD_LOAD_LIST  = 3'd5;

  // Register map: register index taken from paddr[2]
  localparam logic REG_CLUSTER_WORDS_LOG2 = 1'b0;
  localparam logic [LOG2_W-1:0] CWL_RESET = 4'd8;
  localparam logic [LOG2_W-1:0] CWL_MIN   = 4'd2;

  // Special FAT entry values
  localparam logic [31:0] ENTRY_FREE = 32'h7FFF_FFFF;
  localparam logic [31:0] ENTRY_END  = 32'hFFFF_FFFF;
  localparam logic [31:0] ENTRY_TOP  = 32'h8000_0000;

  typedef enum logic [2:0] {
    OP_GET_PLAIN,
    OP_GET_MASK,
    OP_SET,
    OP_SET_RESET,
    OP_LOAD_WORD,
    OP_LOAD_LIST,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic                 oor;     // range fault known before the walk
    logic                 lower;   // set may lower the free mark
    logic [LOG2_W-1:0]    log2;    // effective words-per-cluster log2
    logic [CLUSTER_W-1:0] cluster;
    logic [LIDX_W-1:0]    lidx;
    logic [OFF_W-1:0]     ioff;
    logic [OFF_W-1:0]     off;
    logic [31:0]          data;    // encoded entry or load data
    logic [LADDR_W-1:0]   laddr;
  } item_t;

endpackage

@@ hdl/fet_front.sv @@
// Front end: classifies incoming commands, splits the cluster number and
// queues the result for the back end. Depends on fet_pkg.
module fet_front #(
  parameter int STORE_CLUSTERS    = fet_pkg::DEF_STORE_CLUSTERS,
  parameter int LIST_DEPTH        = fet_pkg::DEF_LIST_DEPTH,
  parameter int MAX_CLUSTER_WORDS = fet_pkg::DEF_MAX_CLUSTER_WORDS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [fet_pkg::LOG2_W-1:0]     cwl_i,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [2:0]                     cmd_i,
  input  logic [fet_pkg::CLUSTER_W-1:0]  cluster_i,
  input  logic [31:0]                    value_i,
  input  logic [fet_pkg::LADDR_W-1:0]    load_address_i,
  output logic                           item_valid_o,
  output fet_pkg::item_t                 item_o,
  input  logic                           item_take_i
);
  import fet_pkg::*;

  localparam int MaxL       = $clog2(MAX_CLUSTER_WORDS + 1) - 1;
  localparam int OffW       = MaxL;
  localparam int StoreDepth = STORE_CLUSTERS * MAX_CLUSTER_WORDS;
  localparam int PtrW       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW       = $clog2(QUEUE_DEPTH + 1);

  logic [LOG2_W-1:0]    l_eff;
  logic [OffW-1:0]      wmask;
  logic [OffW-1:0]      off;
  logic [OffW-1:0]      ioff;
  logic [CLUSTER_W-1:0] lidx_full;
  logic                 lidx_ok;
  logic                 set_keep;
  item_t                cls;

  // Clamp the register to the supported range
  always_comb begin
    if (cwl_i < CWL_MIN) begin
      l_eff = CWL_MIN;
    end else if (cwl_i > LOG2_W'(MaxL)) begin
      l_eff = LOG2_W'(MaxL);
    end else begin
      l_eff = cwl_i;
    end
  end

  assign wmask     = ~({OffW{1'b1}} << l_eff);
  assign off       = OffW'(cluster_i) & wmask;
  assign ioff      = OffW'(cluster_i >> l_eff) & wmask;
  assign lidx_full = cluster_i >> {l_eff, 1'b0};
  assign lidx_ok   = lidx_full < CLUSTER_W'(LIST_DEPTH);
  assign set_keep  = (value_i == ENTRY_FREE) || (value_i == ENTRY_END);

  always_comb begin
    cls         = '0;
    cls.op      = OP_NOP;
    cls.log2    = l_eff;
    cls.cluster = cluster_i;
    cls.lidx    = LIDX_W'(lidx_full);
    cls.ioff    = OFF_W'(ioff);
    cls.off     = OFF_W'(off);
    cls.laddr   = load_address_i;
    cls.data    = value_i;
    unique case (cmd_i)
      CMD_GET_PLAIN: begin
        cls.op  = OP_GET_PLAIN;
        cls.oor = !lidx_ok;
      end
      CMD_GET_MASK: begin
        cls.op  = OP_GET_MASK;
        cls.oor = !lidx_ok;
      end
      CMD_SET: begin
        cls.op    = OP_SET;
        cls.oor   = !lidx_ok;
        cls.lower = (value_i == ENTRY_FREE);
        cls.data  = set_keep ? value_i : (value_i | ENTRY_TOP);
      end
      CMD_SET_RESET: begin
        cls.op    = OP_SET_RESET;
        cls.oor   = !lidx_ok;
        cls.lower = 1'b1;
      end
      CMD_LOAD_WORD: begin
        cls.op  = OP_LOAD_WORD;
        cls.oor = !(32'(load_address_i) < 32'(StoreDepth));
      end
      CMD_LOAD_LIST: begin
        cls.op  = OP_LOAD_LIST;
        cls.oor = !(32'(load_address_i) < 32'(LIST_DEPTH));
      end
      default: cls.op = OP_NOP;
    endcase
  end

  // Short queue towards the back end
  item_t           q_mem [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr_en;

  assign full_o       = (cnt_q == CntW'(QUEUE_DEPTH));
  assign wr_en        = push_i && !full_o;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (item_take_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !item_take_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && item_take_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_i |-> item_valid_o)
    else $error("fet_front: item taken from empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !item_take_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("fet_front: queue count lost a beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("fet_front: pointers disagree on empty queue");

endmodule

@@ hdl/fet_back.sv @@
// Back end: walks the indirect list and cluster store, performs gets, sets
// and loads, keeps the lowest-free mark and the result register. Depends on fet_pkg.
module fet_back #(
  parameter int STORE_CLUSTERS    = fet_pkg::DEF_STORE_CLUSTERS,
  parameter int LIST_DEPTH        = fet_pkg::DEF_LIST_DEPTH,
  parameter int MAX_CLUSTER_WORDS = fet_pkg::DEF_MAX_CLUSTER_WORDS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  input  fet_pkg::item_t                item_i,
  output logic                          item_take_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [31:0]                   entry_value_o,
  output logic [fet_pkg::CLUSTER_W-1:0] lowest_free_o,
  output logic                          out_of_range_o
);
  import fet_pkg::*;

  localparam int MaxL       = $clog2(MAX_CLUSTER_WORDS + 1) - 1;
  localparam int OffW       = MaxL;
  localparam int CW         = $clog2(STORE_CLUSTERS);
  localparam int StoreDepth = STORE_CLUSTERS * MAX_CLUSTER_WORDS;
  localparam int SAW        = $clog2(StoreDepth);
  localparam int LIW        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIST,
    S_IND,
    S_FAT,
    S_DONE
  } state_e;

  state_e               state_q, state_d;
  item_t                cur_q;
  logic [CLUSTER_W-1:0] mark_q, mark_d;

  logic                 out_valid_q;
  logic [31:0]          out_val_q;
  logic [CLUSTER_W-1:0] out_mark_q;
  logic                 out_oor_q;
  logic [31:0]          res_val_q;
  logic [CLUSTER_W-1:0] res_mark_q;
  logic                 res_oor_q;

  logic [31:0] st_mem [StoreDepth];
  logic [15:0] list_mem [LIST_DEPTH];
  logic [31:0] st_rd_q;
  logic [15:0] list_rd_q;

  logic           st_we, list_we;
  logic [SAW-1:0] st_raddr, st_waddr, ind_addr, fat_addr;
  logic [31:0]    st_wdata;
  logic [LIW-1:0] list_raddr, list_waddr;
  logic           fin, fin_oor, lower_now, out_free, pop_ok;
  logic [31:0]    fin_val;

  function automatic logic [31:0] decode_entry(logic [31:0] e, logic mask_mode);
    logic [31:0] r;
    if ((e == ENTRY_FREE) || (e == ENTRY_END)) begin
      r = e;
    end else if (mask_mode) begin
      r = e & ENTRY_TOP;
    end else begin
      r = e & ENTRY_FREE;
    end
    return r;
  endfunction

  assign pop_ok   = pop_i && out_valid_q;
  assign out_free = !out_valid_q || pop_i;

  assign ind_addr = (SAW'(CW'(list_rd_q)) << cur_q.log2) | SAW'(OffW'(cur_q.ioff));
  assign fat_addr = (SAW'(CW'(st_rd_q)) << cur_q.log2) | SAW'(OffW'(cur_q.off));

  always_comb begin
    state_d     = state_q;
    item_take_o = 1'b0;
    st_we       = 1'b0;
    st_waddr    = fat_addr;
    st_wdata    = cur_q.data;
    st_raddr    = fat_addr;
    list_we     = 1'b0;
    list_waddr  = LIW'(item_i.laddr);
    list_raddr  = LIW'(item_i.lidx);
    fin         = 1'b0;
    fin_oor     = 1'b0;
    fin_val     = '0;
    lower_now   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_take_o = 1'b1;
          if (item_i.oor) begin
            fin     = 1'b1;
            fin_oor = 1'b1;
          end else begin
            unique case (item_i.op)
              OP_LOAD_WORD: begin
                st_we    = 1'b1;
                st_waddr = SAW'(item_i.laddr);
                st_wdata = item_i.data;
                fin      = 1'b1;
              end
              OP_LOAD_LIST: begin
                list_we = 1'b1;
                fin     = 1'b1;
              end
              OP_GET_PLAIN, OP_GET_MASK, OP_SET, OP_SET_RESET: begin
                state_d = S_LIST;
              end
              default: fin = 1'b1;
            endcase
          end
        end
      end
      S_LIST: begin
        if (list_rd_q >= 16'(STORE_CLUSTERS)) begin
          fin     = 1'b1;
          fin_oor = 1'b1;
        end else begin
          st_raddr = ind_addr;
          state_d  = S_IND;
        end
      end
      S_IND: begin
        if (st_rd_q >= 32'(STORE_CLUSTERS)) begin
          fin     = 1'b1;
          fin_oor = 1'b1;
        end else if ((cur_q.op == OP_SET) || (cur_q.op == OP_SET_RESET)) begin
          st_we     = 1'b1;
          lower_now = cur_q.lower;
          fin       = 1'b1;
        end else begin
          state_d = S_FAT;
        end
      end
      S_FAT: begin
        fin     = 1'b1;
        fin_val = decode_entry(st_rd_q, cur_q.op == OP_GET_MASK);
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // Finished results go straight out, or wait in the hold register
    if (fin) begin
      state_d = out_free ? S_IDLE : S_DONE;
    end
  end

  assign mark_d = (lower_now && (cur_q.cluster < mark_q)) ? cur_q.cluster : mark_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mark_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mark_q  <= mark_d;
      if ((fin && out_free) || ((state_q == S_DONE) && out_free)) begin
        out_valid_q <= 1'b1;
      end else if (pop_ok) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      cur_q <= item_i;
    end
    if (fin && out_free) begin
      out_val_q  <= fin_val;
      out_mark_q <= mark_d;
      out_oor_q  <= fin_oor;
    end else if ((state_q == S_DONE) && out_free) begin
      out_val_q  <= res_val_q;
      out_mark_q <= res_mark_q;
      out_oor_q  <= res_oor_q;
    end
    if (fin && !out_free) begin
      res_val_q  <= fin_val;
      res_mark_q <= mark_d;
      res_oor_q  <= fin_oor;
    end
  end

  // Cluster store and indirect list, read data registered
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rd_q <= st_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_waddr] <= item_i.data[15:0];
    end
    list_rd_q <= list_mem[list_raddr];
  end

  assign empty_o        = !out_valid_q;
  assign entry_value_o  = out_val_q;
  assign lowest_free_o  = out_mark_q;
  assign out_of_range_o = out_oor_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o |-> (state_q == S_IDLE))
    else $error("fet_back: item taken while a walk is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |-> ((state_q == S_IDLE) || (state_q == S_IND)))
    else $error("fet_back: store written outside a load or set step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (mark_q <= $past(mark_q)))
    else $error("fet_back: lowest-free mark rose");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> out_valid_q)
    else $error("fet_back: result held back with output register free");

endmodule

@@ hdl/fat_entry_table_engine_top.sv @@
// FAT entry table engine: top level with configuration register and APB port.
// Instantiates fet_front and fet_back; depends on fet_pkg.
//
// Commands enter through a queue-style port (push/full): gets and sets walk
// indirect list -> indirect cluster word -> FAT word; two load commands fill
// the cluster store and the indirect list. Every command gives one result
// beat on the output queue port (empty/pop), in command order.
// A load, an unused command or a command faulting on its list index ends in
// the idle state; a set reads the list and indirect cluster word, then writes
// the FAT word, and a get also reads the FAT word. Loads go one per cycle
// while results are popped; with a single read port per memory, no command
// is taken before the last ends. The user must write cluster_words_log2 over
// APB (pready always high) only while idle; the block does not enforce it.
// Reset clears the queues, the mark (to all ones) and the register (to 8);
// store and list contents are undefined until loaded.
// A stalled receiver holds the current result; the back end then keeps one
// further result and the front queue absorbs two commands before full rises.
module fat_entry_table_engine_top #(
  parameter int STORE_CLUSTERS    = fet_pkg::DEF_STORE_CLUSTERS,
  parameter int LIST_DEPTH        = fet_pkg::DEF_LIST_DEPTH,
  parameter int MAX_CLUSTER_WORDS = fet_pkg::DEF_MAX_CLUSTER_WORDS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          push,
  output logic                          full,
  input  logic [2:0]                    cmd_i,
  input  logic [fet_pkg::CLUSTER_W-1:0] cluster_i,
  input  logic [31:0]                   value_i,
  input  logic [fet_pkg::LADDR_W-1:0]   load_address_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [31:0]                   entry_value_o,
  output logic [fet_pkg::CLUSTER_W-1:0] lowest_free_o,
  output logic                          out_of_range_o
);
  import fet_pkg::*;

  logic [LOG2_W-1:0] cwl_q;
  logic              cfg_wr;
  logic              item_valid;
  logic              item_take;
  item_t             item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CLUSTER_WORDS_LOG2);
  assign prdata = (paddr[2] == REG_CLUSTER_WORDS_LOG2) ? 32'(cwl_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cwl_q <= CWL_RESET;
    end else if (cfg_wr) begin
      cwl_q <= pwdata[LOG2_W-1:0];
    end
  end

  fet_front #(
    .STORE_CLUSTERS    (STORE_CLUSTERS),
    .LIST_DEPTH        (LIST_DEPTH),
    .MAX_CLUSTER_WORDS (MAX_CLUSTER_WORDS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cwl_i          (cwl_q),
    .push_i         (push),
    .full_o         (full),
    .cmd_i          (cmd_i),
    .cluster_i      (cluster_i),
    .value_i        (value_i),
    .load_address_i (load_address_i),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .item_take_i    (item_take)
  );

  fet_back #(
    .STORE_CLUSTERS    (STORE_CLUSTERS),
    .LIST_DEPTH        (LIST_DEPTH),
    .MAX_CLUSTER_WORDS (MAX_CLUSTER_WORDS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_i         (item),
    .item_take_o    (item_take),
    .empty_o        (empty),
    .pop_i          (pop),
    .entry_value_o  (entry_value_o),
    .lowest_free_o  (lowest_free_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule
